// ===== design/ttc_pkg.sv =====
// Shared types and constants for the time-over-threshold to charge converter.
// Used by every module of the block; depends on nothing.

package ttc_pkg;

	localparam int TOT_W      = 16;
	localparam int RISE_W     = 10;
	localparam int SLOPE_W    = 10;
	localparam int THR_W      = 16;
	localparam int CHARGE_W   = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int PTS_W  = TOT_W - 1 + SLOPE_W;  // tot * slope, tot known non-negative
	localparam int PSR_W  = SLOPE_W + RISE_W;     // slope * rise_time
	localparam int K_W    = PSR_W + THR_W;        // slope * rise_time * threshold
	localparam int K4_W   = K_W + 2;
	localparam int D_W    = 27;                   // signed D
	localparam int MAG_W  = 26;                   // |D|
	localparam int SQ_W   = 2 * MAG_W;
	localparam int R_W    = 54;                   // radicand
	localparam int ROOT_W = R_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int SUM_W  = ROOT_W + 1;

	localparam int NCELLS       = ROOT_W;
	localparam int FRONT_STAGES = 5;
	localparam int LATENCY      = FRONT_STAGES + NCELLS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_RISE_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [RISE_W-1:0]  RISE_RESET  = 10'd100;
	localparam logic [SLOPE_W-1:0] SLOPE_RESET = 10'd60;
	localparam logic [THR_W-1:0]   THR_RESET   = 16'd3000;

	typedef struct packed {
		logic [RISE_W-1:0]  rise_time;
		logic [SLOPE_W-1:0] slope;
		logic [THR_W-1:0]   threshold;
	} cfg_t;

	// sideband that travels with an item down the root chain
	typedef struct packed {
		logic             err;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} side_t;

	typedef struct packed {
		logic [R_W-1:0]    x;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

endpackage

// ===== design/ttc_front.sv =====
// Arithmetic front end: five pipeline stages that form D, |D| and the radicand R.
// Depends on ttc_pkg.

module ttc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ttc_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	input  logic [ttc_pkg::TOT_W-1:0]      tot_ticks,
	output logic                           out_valid,
	output ttc_pkg::side_t                 out_side,
	output logic [ttc_pkg::R_W-1:0]        out_r
);

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                          err_s1, err_s2, err_s3, err_s4, err_s5;
	logic [ttc_pkg::PTS_W-1:0]     pts_s1;
	logic [ttc_pkg::PSR_W-1:0]     psr_s1;
	logic [ttc_pkg::D_W-1:0]       d_s2;
	logic [ttc_pkg::K_W-1:0]       k_s2;
	logic                          neg_s3, neg_s4, neg_s5;
	logic [ttc_pkg::MAG_W-1:0]     mag_s3, mag_s4, mag_s5;
	logic [ttc_pkg::K4_W-1:0]      k4_s3, k4_s4;
	logic [ttc_pkg::SQ_W-1:0]      sq_s4;
	logic [ttc_pkg::R_W-1:0]       r_s5;
	logic [ttc_pkg::D_W-1:0]       d_neg;

	assign d_neg = -d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: the two independent products
		err_s1 <= tot_ticks[ttc_pkg::TOT_W-1];
		pts_s1 <= tot_ticks[ttc_pkg::TOT_W-2:0] * cfg.slope;
		psr_s1 <= cfg.slope * cfg.rise_time;
		// stage 2: D and the constant term of R
		err_s2 <= err_s1;
		d_s2   <= ttc_pkg::D_W'(cfg.threshold) + ttc_pkg::D_W'(pts_s1)
			- ttc_pkg::D_W'(psr_s1);
		k_s2   <= psr_s1 * cfg.threshold;
		// stage 3: magnitude of D
		err_s3 <= err_s2;
		neg_s3 <= d_s2[ttc_pkg::D_W-1];
		mag_s3 <= d_s2[ttc_pkg::D_W-1] ? d_neg[ttc_pkg::MAG_W-1:0]
			: d_s2[ttc_pkg::MAG_W-1:0];
		k4_s3  <= {k_s2, 2'b00};
		// stage 4: square
		err_s4 <= err_s3;
		neg_s4 <= neg_s3;
		mag_s4 <= mag_s3;
		k4_s4  <= k4_s3;
		sq_s4  <= mag_s3 * mag_s3;
		// stage 5: radicand
		err_s5 <= err_s4;
		neg_s5 <= neg_s4;
		mag_s5 <= mag_s4;
		r_s5   <= ttc_pkg::R_W'(sq_s4) + ttc_pkg::R_W'(k4_s4);
	end

	assign out_valid     = v_s5;
	assign out_side.err  = err_s5;
	assign out_side.neg  = neg_s5;
	assign out_side.mag  = mag_s5;
	assign out_r         = r_s5;

endmodule

// ===== design/ttc_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per item and hands
// the partial remainder, root and sideband to the next cell. Depends on ttc_pkg.

module ttc_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ttc_pkg::side_t  in_side,
	input  ttc_pkg::sqrt_t  in_sq,
	output logic            out_valid,
	output ttc_pkg::side_t  out_side,
	output ttc_pkg::sqrt_t  out_sq
);

	logic [ttc_pkg::REM_W-1:0] rem_sh;
	logic [ttc_pkg::REM_W-1:0] trial;
	logic                      ge;
	logic                      valid_q;
	ttc_pkg::side_t            side_q;
	ttc_pkg::sqrt_t            sq_q;

	// bring down the next two radicand bits, try root*4+1
	assign rem_sh = {in_sq.rem[ttc_pkg::REM_W-3:0], in_sq.x[ttc_pkg::R_W-1 -: 2]};
	assign trial  = {in_sq.root[ttc_pkg::REM_W-3:0], 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q  <= in_side;
		sq_q.x  <= {in_sq.x[ttc_pkg::R_W-3:0], 2'b00};
		sq_q.rem <= ge ? rem_sh - trial : rem_sh;
		sq_q.root <= {in_sq.root[ttc_pkg::ROOT_W-2:0], ge};
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_sq    = sq_q;

endmodule

// ===== design/tot_to_charge_converter.sv =====
// Top level of the time-over-threshold to charge converter.
// Depends on ttc_pkg, ttc_front and ttc_sqrt_cell.
//
// Usage:
//   Input: drive tot_ticks and raise start; an item is taken at every edge with
//   start high and busy low. busy stays low, so one item enters per cycle.
//   Output: each item gives one result on charge/error, shown for one cycle
//   with done high. Between the accepting edge and the result lie 5 front-end
//   stages (products, D, |D|, square, radicand), 27 square root cells (one
//   root bit each) and 1 output register.
//   Throughput: one item per cycle, set by the fully pipelined root chain.
//   A negative tot_ticks gives error = 1 and charge = 0.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 rise_time, 1 slope,
//   2 threshold) and cfg_data; cfg_ready is always high, index 3 is ignored.
//   Write configuration only while no item is in flight.
//   Reset: arst_n clears the pipeline (no results come out) and loads
//   rise_time 100, slope 60, threshold 3000.
//   The receiver cannot stall; results must be taken when done is high.

module tot_to_charge_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [ttc_pkg::TOT_W-1:0]          tot_ticks,
	output logic                               done,
	output logic [ttc_pkg::CHARGE_W-1:0]       charge,
	output logic                               error,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ttc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ttc_pkg::cfg_t   cfg_q;
	logic            accept;
	logic            chain_v    [ttc_pkg::NCELLS+1];
	ttc_pkg::side_t  chain_side [ttc_pkg::NCELLS+1];
	ttc_pkg::sqrt_t  chain_sq   [ttc_pkg::NCELLS+1];
	logic [ttc_pkg::R_W-1:0] front_r;
	ttc_pkg::side_t  last_side;
	logic [ttc_pkg::ROOT_W-1:0] last_root;
	logic [ttc_pkg::SUM_W-1:0]  sum;
	logic            done_q;
	logic            error_q;
	logic [ttc_pkg::CHARGE_W-1:0] charge_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_time <= ttc_pkg::RISE_RESET;
			cfg_q.slope     <= ttc_pkg::SLOPE_RESET;
			cfg_q.threshold <= ttc_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ttc_pkg::REG_RISE_TIME: begin
					cfg_q.rise_time <= cfg_data[ttc_pkg::RISE_W-1:0];
				end
				ttc_pkg::REG_SLOPE: begin
					cfg_q.slope <= cfg_data[ttc_pkg::SLOPE_W-1:0];
				end
				ttc_pkg::REG_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[ttc_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ttc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (accept),
		.tot_ticks (tot_ticks),
		.out_valid (chain_v[0]),
		.out_side  (chain_side[0]),
		.out_r     (front_r)
	);

	assign chain_sq[0].x    = front_r;
	assign chain_sq[0].rem  = '0;
	assign chain_sq[0].root = '0;

	for (genvar i = 0; i < ttc_pkg::NCELLS; i++) begin : g_cell
		ttc_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_v[i]),
			.in_side   (chain_side[i]),
			.in_sq     (chain_sq[i]),
			.out_valid (chain_v[i+1]),
			.out_side  (chain_side[i+1]),
			.out_sq    (chain_sq[i+1])
		);
	end

	assign last_side = chain_side[ttc_pkg::NCELLS];
	assign last_root = chain_sq[ttc_pkg::NCELLS].root;

	// D + sqrt(R), with D given as sign and magnitude; never negative
	assign sum = last_side.neg
		? ttc_pkg::SUM_W'(last_root) - ttc_pkg::SUM_W'(last_side.mag)
		: ttc_pkg::SUM_W'(last_root) + ttc_pkg::SUM_W'(last_side.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_v[ttc_pkg::NCELLS];
		end
	end

	always_ff @(posedge clk) begin
		error_q  <= last_side.err;
		charge_q <= last_side.err ? '0 : sum[ttc_pkg::CHARGE_W:1];
	end

	assign done   = done_q;
	assign error  = error_q;
	assign charge = charge_q;

endmodule

// ===== design/ttc_checker.sv =====
// Port-level checker for tot_to_charge_converter, attached with bind below.
// Depends on ttc_pkg.

module ttc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [ttc_pkg::TOT_W-1:0]      tot_ticks,
	input  logic                           done,
	input  logic [ttc_pkg::CHARGE_W-1:0]   charge,
	input  logic                           error
);

	// every accepted item comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ttc_pkg::LATENCY) done)
		else $error("accepted item gave no result at the expected cycle");

	// no result without an item accepted the latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ttc_pkg::LATENCY))
		else $error("result without a matching accepted item");

	// a negative measurement flags an error in its result
	a_neg_error: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && tot_ticks[ttc_pkg::TOT_W-1]) |-> ##(ttc_pkg::LATENCY)
		(done && error))
		else $error("negative measurement did not raise error");

	// an error result carries zero charge
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (charge == '0))
		else $error("error result with nonzero charge");

endmodule

bind tot_to_charge_converter ttc_checker u_ttc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.tot_ticks (tot_ticks),
	.done      (done),
	.charge    (charge),
	.error     (error)
);

// ===== tb/sv/tot_to_charge_converter_test.sv =====
// Self-checking testbench for tot_to_charge_converter: charge reconstruction per item,
// checked against an integer predictor under several register settings.
// Depends on ttc_pkg and the tot_to_charge_converter RTL.

module tot_to_charge_converter_test;
	import ttc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 235;

	typedef struct packed {
		logic [CHARGE_W-1:0] charge;
		logic                error;
	} charge_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [TOT_W-1:0]      tot_ticks = '0;
	logic                  done;
	logic [CHARGE_W-1:0]   charge;
	logic                  error;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic [RISE_W-1:0]  rise_cfg = RISE_RESET;
	logic [SLOPE_W-1:0] slope_cfg = SLOPE_RESET;
	logic [THR_W-1:0]   thr_cfg = THR_RESET;

	logic [TOT_W-1:0] tot_backlog[$];
	charge_t          charge_expected[$];
	charge_t          oldest;
	logic             took = 1'b0;
	logic             steady = 1'b0;
	int               cyc = 0;
	int               mismatches = 0;
	int               items_taken = 0;
	int               results_checked = 0;
	int               neg_results = 0;
	int               cfg_writes = 0;

	tot_to_charge_converter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.tot_ticks (tot_ticks),
		.done      (done),
		.charge    (charge),
		.error     (error),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic charge_t reconstruct_charge(input logic signed [TOT_W-1:0] tot);
		charge_t         res;
		longint          d;
		longint unsigned mag;
		longint unsigned rad;
		longint unsigned root;
		longint unsigned sum;
		if (tot < 0) begin
			res.charge = '0;
			res.error = 1'b1;
			return res;
		end
		d = longint'(thr_cfg) + longint'(tot) * longint'(slope_cfg)
			- longint'(slope_cfg) * longint'(rise_cfg);
		mag = (d < 0) ? longint'(-d) : longint'(d);
		rad = mag * mag + 64'd4 * slope_cfg * thr_cfg * rise_cfg;
		root = floor_root(rad);
		sum = (d < 0) ? root - mag : root + mag;
		res.charge = sum[CHARGE_W:1];
		res.error = 1'b0;
		return res;
	endfunction

	function automatic logic [TOT_W-1:0] random_tot();
		case ($urandom_range(0, 7))
			0, 1:    return {1'b1, 15'($urandom)};
			2, 3, 4: return TOT_W'($urandom_range(0, 2 * rise_cfg + 64));
			default: return {1'b0, 15'($urandom)};
		endcase
	endfunction

	// Driver: hold the item until it is taken, then advance or idle.
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (!start || took) begin
			if (tot_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 20)) begin
				start <= 1'b1;
				tot_ticks <= tot_backlog.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results before queuing this edge's item.
	always @(posedge clk) begin
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (charge_expected.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result charge %0d error %0b", $time, charge, error);
				end else begin
					oldest = charge_expected.pop_front();
					results_checked++;
					if (oldest.error)
						neg_results++;
					if (oldest.charge !== charge) begin
						mismatches++;
						$display("%0t: charge mismatch: expected %0d, actual %0d",
							$time, oldest.charge, charge);
					end
					if (oldest.error !== error) begin
						mismatches++;
						$display("%0t: error flag mismatch: expected %0b, actual %0b",
							$time, oldest.error, error);
					end
				end
			end
			if (start && !busy) begin
				charge_expected.push_back(reconstruct_charge(tot_ticks));
				items_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					REG_RISE_TIME: rise_cfg = cfg_data[RISE_W-1:0];
					REG_SLOPE:     slope_cfg = cfg_data[SLOPE_W-1:0];
					REG_THRESHOLD: thr_cfg = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, charge_expected.size());
			$display("** tot_to_charge_converter: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		repeat ($urandom_range(0, 2)) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_pipeline();
		while (tot_backlog.size() != 0 || start || charge_expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [RISE_W-1:0]  rise_set[PHASES];
		logic [SLOPE_W-1:0] slope_set[PHASES];
		logic [THR_W-1:0]   thr_set[PHASES];
		rise_set  = '{100, 0, 1023, 0, 1023, 0, 0, 100};
		slope_set = '{60, 0, 1023, 1023, 1, 0, 0, 60};
		thr_set   = '{3000, 0, 65535, 65535, 0, 0, 0, 3000};
		rise_set[5]  = RISE_W'($urandom);
		slope_set[5] = SLOPE_W'($urandom);
		thr_set[5]   = THR_W'($urandom);
		rise_set[6]  = RISE_W'($urandom_range(0, 200));
		slope_set[6] = SLOPE_W'($urandom_range(1, 1023));
		thr_set[6]   = THR_W'($urandom);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: D crosses zero at tot 50, extremes and bit patterns.
		tot_backlog = '{16'd0, 16'd1, 16'd49, 16'd50, 16'd51, 16'd99, 16'd100, 16'd101,
			16'd1000, 16'h7FFF, 16'h7FFE, 16'hFFFF, 16'h8000, 16'h8001, 16'h5555,
			16'h2AAA, 16'hAAAA, 16'd25, 16'd0, 16'h7FFF};

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_pipeline();
				write_reg(REG_RISE_TIME, {6'($urandom), rise_set[p]});
				write_reg(REG_SLOPE, {6'($urandom), slope_set[p]});
				write_reg(REG_THRESHOLD, thr_set[p]);
				write_reg(REG_UNUSED, 16'($urandom));
				if (p == 1)
					tot_backlog = '{16'd0, 16'h7FFF, 16'h8000, 16'hFFFF};
				if (p == 2)
					tot_backlog = '{16'd0, 16'd1023, 16'd1022, 16'h7FFF, 16'h8000};
			end
			steady = (p == 3);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				tot_backlog.push_back(random_tot());
		end

		drain_pipeline();
		repeat (LATENCY + 8) @(posedge clk);
		if (charge_expected.size() != 0) begin
			mismatches++;
			$display("%0t: %0d expected results never arrived", $time, charge_expected.size());
		end
		$display("Checked %0d charge results (%0d flagged negative) from %0d items",
			results_checked, neg_results, items_taken);
		$display("across %0d register settings with %0d register writes",
			PHASES, cfg_writes);
		if (mismatches == 0)
			$display("** tot_to_charge_converter: PASSED **");
		else
			$display("** tot_to_charge_converter: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
design/ttc_pkg.sv
design/ttc_front.sv
design/ttc_sqrt_cell.sv
design/tot_to_charge_converter.sv
design/ttc_checker.sv
tb/sv/tot_to_charge_converter_test.sv
